### src/cqf_pkg.sv
// Shared types and codes for the circular queue FIFO core.
// Holds the field widths, action and status codes and the sequencer state type.
// No dependencies.
`timescale 1ns / 1ps

package cqf_pkg;

    // Fixed widths of the channel fields.
    localparam int ACTION_W = 2;
    localparam int VALUE_W  = 32;
    localparam int STATUS_W = 2;
    localparam int CAP_W    = 5;

    // Action codes carried on the input channel.
    localparam logic [ACTION_W-1:0] ACT_ENQUEUE = 2'd0;
    localparam logic [ACTION_W-1:0] ACT_DEQUEUE = 2'd1;
    localparam logic [ACTION_W-1:0] ACT_DISPLAY = 2'd2;

    // Status codes carried on the output channel.
    localparam logic [STATUS_W-1:0] STAT_OK    = 2'd0;
    localparam logic [STATUS_W-1:0] STAT_FULL  = 2'd1;
    localparam logic [STATUS_W-1:0] STAT_EMPTY = 2'd2;

    // Sequencer states.
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_READ,
        ST_OUT
    } cqf_state_t;

endpackage

### src/circular_queue_fifo_core.sv
// Top level of the circular queue FIFO core: sequencer, indices and output register.
// Depends on cqf_pkg and on cqf_ram for the slot storage.
//
//   Channel   Handshake              Payload
//   --------  ---------------------  ------------------------------
//   in        in_valid / in_ready    action[1:0], value[31:0] signed
//   out       out_valid / out_ready  status[1:0], data[31:0] signed, last
//   cfg       cfg_valid / cfg_ready  capacity[4:0]
//
// Enqueue, and any action on an empty queue, goes from IDLE straight to OUT.
// A good dequeue passes through READ before OUT, and a display passes through
// READ and OUT once per listed entry: each slot read goes through the registered
// read port of the slot memory before it reaches the output register.
// Action code 3 is accepted and produces no word. Reset empties the queue and
// sets the capacity to DEPTH; the slot memory itself is not cleared.
// A stall on the output holds the sequencer; no new word is taken meanwhile.
`timescale 1ns / 1ps

module circular_queue_fifo_core
    import cqf_pkg::*;
#(
    parameter int DEPTH = 16
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       in_valid,
    output logic                       in_ready,
    input  logic [ACTION_W-1:0]        action,
    input  logic signed [VALUE_W-1:0]  value,
    output logic                       out_valid,
    input  logic                       out_ready,
    output logic [STATUS_W-1:0]        status,
    output logic signed [VALUE_W-1:0]  data,
    output logic                       last,
    input  logic                       cfg_valid,
    output logic                       cfg_ready,
    input  logic [CAP_W-1:0]           capacity
);

    // Index width addresses the slots; count width also holds DEPTH itself.
    localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW   = $clog2(DEPTH + 1);
    localparam int CMPW = (CW > CAP_W) ? CW : CAP_W;

    cqf_state_t state_reg, state_next;

    logic [AW-1:0]       head_reg, head_next;
    logic [AW-1:0]       tail_reg, tail_next;
    logic [AW-1:0]       walk_reg, walk_next;
    logic [CW-1:0]       count_reg, count_next;
    logic [CW-1:0]       rem_reg, rem_next;
    logic [CW-1:0]       cap_reg, cap_next;
    logic [ACTION_W-1:0] op_reg, op_next;

    logic [STATUS_W-1:0]       out_status_reg, out_status_next;
    logic signed [VALUE_W-1:0] out_data_reg, out_data_next;
    logic                      out_last_reg, out_last_next;

    logic               in_fire;
    logic               cfg_fire;
    logic               is_empty;
    logic               is_full;
    logic               walk_more;
    logic [AW-1:0]      walk_adv;
    logic [CW-1:0]      cap_clamped;
    logic [CMPW-1:0]    cap_wide;

    logic               ram_we;
    logic               ram_re;
    logic [AW-1:0]      ram_raddr;
    logic [VALUE_W-1:0] ram_rdata;

    // Step an index round the ring of active slots.
    function automatic logic [AW-1:0] advance(input logic [AW-1:0] idx,
                                              input logic [CW-1:0] cap);
        logic [CW-1:0] inc;
        inc = CW'(idx) + CW'(1);
        return (inc >= cap) ? '0 : inc[AW-1:0];
    endfunction

    assign in_fire   = in_valid && in_ready;
    assign cfg_fire  = cfg_valid && cfg_ready;
    assign is_empty  = (count_reg == '0);
    assign is_full   = (count_reg >= cap_reg);
    assign walk_adv  = advance(walk_reg, cap_reg);
    assign walk_more = (op_reg == ACT_DISPLAY) && !out_last_reg;

    // Clamp the written capacity into 1 to DEPTH.
    assign cap_wide = CMPW'(capacity);
    always_comb
    begin
        if (capacity == '0)
        begin
            cap_clamped = CW'(1);
        end
        else if (cap_wide > CMPW'(DEPTH))
        begin
            cap_clamped = CW'(DEPTH);
        end
        else
        begin
            cap_clamped = CW'(cap_wide);
        end
    end

    // Next state of the sequencer.
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_fire)
                begin
                    case (action)
                        ACT_ENQUEUE: state_next = ST_OUT;
                        ACT_DEQUEUE,
                        ACT_DISPLAY: state_next = is_empty ? ST_OUT : ST_READ;
                        default:     state_next = ST_IDLE;
                    endcase
                end
            end
            ST_READ:
            begin
                state_next = ST_OUT;
            end
            ST_OUT:
            begin
                if (out_ready)
                begin
                    state_next = walk_more ? ST_READ : ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Handshake outputs and slot memory controls.
    always_comb
    begin
        in_ready  = (state_reg == ST_IDLE) && !cfg_valid;
        cfg_ready = (state_reg == ST_IDLE);
        out_valid = (state_reg == ST_OUT);
        ram_we    = (state_reg == ST_IDLE) && in_fire && (action == ACT_ENQUEUE) && !is_full;
        ram_re    = ((state_reg == ST_IDLE) && in_fire && !is_empty
                     && ((action == ACT_DEQUEUE) || (action == ACT_DISPLAY)))
                    || ((state_reg == ST_OUT) && out_ready && walk_more);
        ram_raddr = (state_reg == ST_IDLE) ? head_reg : walk_adv;
    end

    // Indices, counters and the output word.
    always_comb
    begin
        head_next       = head_reg;
        tail_next       = tail_reg;
        walk_next       = walk_reg;
        count_next      = count_reg;
        rem_next        = rem_reg;
        cap_next        = cap_reg;
        op_next         = op_reg;
        out_status_next = out_status_reg;
        out_data_next   = out_data_reg;
        out_last_next   = out_last_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (cfg_fire)
                begin
                    cap_next   = cap_clamped;
                    head_next  = '0;
                    tail_next  = '0;
                    count_next = '0;
                end
                else if (in_fire)
                begin
                    op_next       = action;
                    walk_next     = head_reg;
                    rem_next      = count_reg;
                    out_data_next = '0;
                    out_last_next = 1'b1;
                    if (action == ACT_ENQUEUE)
                    begin
                        if (is_full)
                        begin
                            out_status_next = STAT_FULL;
                        end
                        else
                        begin
                            out_status_next = STAT_OK;
                            tail_next       = advance(tail_reg, cap_reg);
                            count_next      = count_reg + CW'(1);
                        end
                    end
                    else
                    begin
                        out_status_next = STAT_EMPTY;
                    end
                end
            end
            ST_READ:
            begin
                out_status_next = STAT_OK;
                out_data_next   = ram_rdata;
                if (op_reg == ACT_DEQUEUE)
                begin
                    out_last_next = 1'b1;
                    head_next     = advance(head_reg, cap_reg);
                    count_next    = count_reg - CW'(1);
                end
                else
                begin
                    out_last_next = (rem_reg == CW'(1));
                end
            end
            ST_OUT:
            begin
                if (out_ready && walk_more)
                begin
                    walk_next = walk_adv;
                    rem_next  = rem_reg - CW'(1);
                end
            end
            default:
            begin
            end
        endcase
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            head_reg  <= '0;
            tail_reg  <= '0;
            walk_reg  <= '0;
            count_reg <= '0;
            rem_reg   <= '0;
            cap_reg   <= CW'(DEPTH);
            op_reg    <= ACT_ENQUEUE;
        end
        else
        begin
            state_reg <= state_next;
            head_reg  <= head_next;
            tail_reg  <= tail_next;
            walk_reg  <= walk_next;
            count_reg <= count_next;
            rem_reg   <= rem_next;
            cap_reg   <= cap_next;
            op_reg    <= op_next;
        end
    end

    // Output word register.
    always_ff @(posedge clk)
    begin
        out_status_reg <= out_status_next;
        out_data_reg   <= out_data_next;
        out_last_reg   <= out_last_next;
    end

    assign status = out_status_reg;
    assign data   = out_data_reg;
    assign last   = out_last_reg;

    // Slot storage.
    cqf_ram #(
        .WIDTH (VALUE_W),
        .DEPTH (DEPTH)
    ) u_slots (
        .clk     (clk),
        .wr_en   (ram_we),
        .wr_addr (tail_reg),
        .wr_data (value),
        .rd_en   (ram_re),
        .rd_addr (ram_raddr),
        .rd_data (ram_rdata)
    );

    // The fill level never passes the active capacity.
    a_count_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= cap_reg)
        else $error("entry count exceeds capacity");

    // The write index stays inside the active ring.
    a_tail_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        CW'(tail_reg) < cap_reg)
        else $error("tail index outside the active slots");

    // A slot is only written when the queue has room.
    a_write_has_room: assert property (@(posedge clk) disable iff (!rst_n)
        ram_we |-> (count_reg < cap_reg))
        else $error("slot written on a full queue");

    // An empty word is only offered while the queue holds nothing.
    a_empty_status: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && (status == STAT_EMPTY)) |-> is_empty)
        else $error("empty status with entries stored");

    // The READ state is always followed by OUT, where the read data is presented.
    a_read_to_out: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_READ) |=> (state_reg == ST_OUT))
        else $error("read data not presented");

endmodule

### src/cqf_ram.sv
// Generic single-port-write, single-port-read RAM with a registered read.
// Used for the slot storage of the circular queue FIFO core. No dependencies.
`timescale 1ns / 1ps

module cqf_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  logic                                    clk,
    input  logic                                    wr_en,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
    input  logic [WIDTH-1:0]                        wr_data,
    input  logic                                    rd_en,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
    output logic [WIDTH-1:0]                        rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    // Write port.
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    // Registered read port.
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

### sim/circular_queue_fifo_core_test.sv
// Self-checking testbench for the circular queue FIFO core.
// Drives enqueue, dequeue and display words, rewrites the capacity between phases and
// checks every output word against an in-bench ring model. Depends on cqf_pkg and the core.
`timescale 1ns / 1ps

module circular_queue_fifo_core_test;
    import cqf_pkg::*;

    localparam int DEPTH         = 16;
    localparam int CLK_PERIOD    = 20;
    localparam int RESET_CYCLES  = 7;
    localparam int SETTLE_CYCLES = 8;
    localparam int MAX_IDLE      = 17;
    localparam int RANDOM_ITEMS  = 125;
    localparam int LIMIT_CYCLES  = 400000;

    // Action code that the core accepts and ignores.
    localparam logic [ACTION_W-1:0] ACT_UNUSED = 2'd3;

    typedef struct packed {
        logic [STATUS_W-1:0]       status;
        logic signed [VALUE_W-1:0] data;
        logic                      last;
    } fifo_word_t;

    typedef enum logic {
        ROW_ITEM,
        ROW_CAPACITY
    } row_kind_t;

    typedef struct {
        row_kind_t                 kind;
        logic [ACTION_W-1:0]       act;
        logic signed [VALUE_W-1:0] val;
        logic [CAP_W-1:0]          cap;
        bit                        typed;
        logic [STATUS_W-1:0]       t_status;
        logic signed [VALUE_W-1:0] t_data;
    } stim_row_t;

    logic                      clk       = 1'b0;
    logic                      rst_n     = 1'b0;
    logic                      in_valid  = 1'b0;
    logic                      in_ready;
    logic [ACTION_W-1:0]       action    = ACT_ENQUEUE;
    logic signed [VALUE_W-1:0] value     = '0;
    logic                      out_valid;
    logic                      out_ready = 1'b0;
    logic [STATUS_W-1:0]       status;
    logic signed [VALUE_W-1:0] data;
    logic                      last;
    logic                      cfg_valid = 1'b0;
    logic                      cfg_ready;
    logic [CAP_W-1:0]          capacity  = '0;

    // Ring model state and the words it still owes.
    logic signed [VALUE_W-1:0] ring [DEPTH];
    int unsigned               ring_head  = 0;
    int unsigned               ring_tail  = 0;
    int unsigned               ring_count = 0;
    int unsigned               ring_cap   = DEPTH;
    fifo_word_t                owed_words [$];
    fifo_word_t                fresh_words [$];

    stim_row_t                 stim_table [$];
    bit                        no_idle      = 1'b0;
    int                        failures     = 0;
    int                        items_sent   = 0;
    int                        words_seen   = 0;
    int                        full_seen    = 0;
    int                        empty_seen   = 0;
    int                        cap_writes   = 0;
    int unsigned               longest_list = 0;
    int                        cycle_count  = 0;

    circular_queue_fifo_core #(
        .DEPTH(DEPTH)
    ) dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .action   (action),
        .value    (value),
        .out_valid(out_valid),
        .out_ready(out_ready),
        .status   (status),
        .data     (data),
        .last     (last),
        .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready),
        .capacity (capacity)
    );

    always #(CLK_PERIOD / 2) clk = ~clk;

    // Watchdog on the total run length.
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count == LIMIT_CYCLES)
        begin
            $display("Timeout after %0d cycles with %0d words owed", cycle_count,
                     owed_words.size());
            $display("*** FAILED ***");
            $finish;
        end
    end

    // Next ring index, wrapping at the active capacity.
    function automatic int unsigned ring_next(input int unsigned idx);
        return (idx + 1 >= ring_cap) ? 0 : idx + 1;
    endfunction

    function automatic void add_word(input logic [STATUS_W-1:0] st,
                                     input logic signed [VALUE_W-1:0] d,
                                     input logic lst);
        fifo_word_t w;
        w.status = st;
        w.data   = d;
        w.last   = lst;
        fresh_words.push_back(w);
    endfunction

    // Applies one action to the ring model and leaves its words in fresh_words.
    function automatic void ring_action(input logic [ACTION_W-1:0] act,
                                        input logic signed [VALUE_W-1:0] val);
        int unsigned idx;
        fresh_words.delete();
        case (act)
            ACT_ENQUEUE:
            begin
                if (ring_count >= ring_cap)
                begin
                    add_word(STAT_FULL, '0, 1'b1);
                end
                else
                begin
                    ring[ring_tail] = val;
                    ring_tail = ring_next(ring_tail);
                    ring_count++;
                    add_word(STAT_OK, '0, 1'b1);
                end
            end
            ACT_DEQUEUE:
            begin
                if (ring_count == 0)
                begin
                    add_word(STAT_EMPTY, '0, 1'b1);
                end
                else
                begin
                    add_word(STAT_OK, ring[ring_head], 1'b1);
                    ring_head = ring_next(ring_head);
                    ring_count--;
                end
            end
            ACT_DISPLAY:
            begin
                if (ring_count == 0)
                begin
                    add_word(STAT_EMPTY, '0, 1'b1);
                end
                else
                begin
                    idx = ring_head;
                    for (int unsigned i = 0; i < ring_count; i++)
                    begin
                        add_word(STAT_OK, ring[idx], i + 1 == ring_count);
                        idx = ring_next(idx);
                    end
                    if (ring_count > longest_list)
                        longest_list = ring_count;
                end
            end
            default:
            begin
                // The unused code leaves the queue alone and yields no word.
            end
        endcase
    endfunction

    // A capacity write clamps to 1..DEPTH and empties the ring.
    function automatic void ring_set_capacity(input logic [CAP_W-1:0] v);
        if (v == 0)
            ring_cap = 1;
        else if (v > DEPTH)
            ring_cap = DEPTH;
        else
            ring_cap = 32'(v);
        ring_head  = 0;
        ring_tail  = 0;
        ring_count = 0;
    endfunction

    function automatic void add_item(input logic [ACTION_W-1:0] act,
                                     input logic signed [VALUE_W-1:0] val);
        stim_row_t r;
        r.kind     = ROW_ITEM;
        r.act      = act;
        r.val      = val;
        r.cap      = '0;
        r.typed    = 1'b0;
        r.t_status = STAT_OK;
        r.t_data   = '0;
        stim_table.push_back(r);
    endfunction

    function automatic void add_known(input logic [ACTION_W-1:0] act,
                                      input logic signed [VALUE_W-1:0] val,
                                      input logic [STATUS_W-1:0] st,
                                      input logic signed [VALUE_W-1:0] d);
        add_item(act, val);
        stim_table[stim_table.size() - 1].typed    = 1'b1;
        stim_table[stim_table.size() - 1].t_status = st;
        stim_table[stim_table.size() - 1].t_data   = d;
    endfunction

    function automatic void add_capacity(input logic [CAP_W-1:0] v);
        add_item(ACT_UNUSED, '0);
        stim_table[stim_table.size() - 1].kind = ROW_CAPACITY;
        stim_table[stim_table.size() - 1].cap  = v;
    endfunction

    // Sends one input word after a random gap and records the words it should cause.
    task automatic send_item(input logic [ACTION_W-1:0] act,
                             input logic signed [VALUE_W-1:0] val,
                             input bit typed,
                             input logic [STATUS_W-1:0] t_status,
                             input logic signed [VALUE_W-1:0] t_data);
        int gap;
        fifo_word_t w;
        gap = no_idle ? 0 : $urandom_range(0, MAX_IDLE);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        action   <= act;
        value    <= val;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        ring_action(act, val);
        if (typed)
        begin
            w.status = t_status;
            w.data   = t_data;
            w.last   = 1'b1;
            fresh_words.delete();
            fresh_words.push_back(w);
        end
        foreach (fresh_words[i])
            owed_words.push_back(fresh_words[i]);
        if (act != ACT_UNUSED)
            items_sent++;
    endtask

    // Holds the input off until every owed word has come and the core has settled.
    task automatic drain_outputs();
        in_valid <= 1'b0;
        @(posedge clk);
        while (owed_words.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_capacity(input logic [CAP_W-1:0] v);
        drain_outputs();
        cfg_valid <= 1'b1;
        capacity  <= v;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        cfg_valid <= 1'b0;
        ring_set_capacity(v);
        cap_writes++;
    endtask

    function automatic logic signed [VALUE_W-1:0] pick_value();
        case ($urandom_range(0, 15))
            0:       return 32'sh7FFF_FFFF;
            1:       return 32'sh8000_0000;
            2:       return '0;
            3:       return '1;
            default: return $urandom;
        endcase
    endfunction

    // Fill-biased actions early in a phase, drain-biased later on.
    function automatic logic [ACTION_W-1:0] pick_action(input bit filling);
        int r;
        r = $urandom_range(0, 99);
        if (r >= 95)
            return ACT_UNUSED;
        if (r >= 80)
            return ACT_DISPLAY;
        if (filling)
            return (r < 65) ? ACT_ENQUEUE : ACT_DEQUEUE;
        return (r < 20) ? ACT_ENQUEUE : ACT_DEQUEUE;
    endfunction

    // Output side: random back-pressure, then check each accepted word in order.
    initial
    begin
        int stall;
        fifo_word_t want;
        wait (rst_n === 1'b1);
        forever
        begin
            stall = no_idle ? 0 : $urandom_range(0, MAX_IDLE);
            if (stall > 0)
            begin
                out_ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            out_ready <= 1'b1;
            @(posedge clk);
            while (out_valid !== 1'b1)
                @(posedge clk);
            words_seen++;
            if (status == STAT_FULL)
                full_seen++;
            if (status == STAT_EMPTY)
                empty_seen++;
            if (owed_words.size() == 0)
            begin
                $error("Unexpected word: status %0d, data %0d, last %0b", status, data, last);
                failures++;
            end
            else
            begin
                want = owed_words.pop_front();
                if (status !== want.status)
                begin
                    $error("status: expected %0d, got %0d", want.status, status);
                    failures++;
                end
                if (data !== want.data)
                begin
                    $error("data: expected %0d, got %0d", want.data, data);
                    failures++;
                end
                if (last !== want.last)
                begin
                    $error("last: expected %0b, got %0b", want.last, last);
                    failures++;
                end
            end
        end
    end

    // Stimulus: reset, the directed table, then random phases at several capacities.
    initial
    begin
        int                  phase;
        int                  phase_len;
        int unsigned         eff_cap;
        logic [CAP_W-1:0]    cap_plan [6];
        logic [CAP_W-1:0]    cap_value;
        logic [ACTION_W-1:0] act;
        int                  random_items;

        cap_plan = '{5'd16, 5'd1, 5'd31, 5'd0, 5'd2, 5'd17};

        // Empty queue at reset, then the field extremes and the ignored code.
        add_known(ACT_DEQUEUE, '0, STAT_EMPTY, '0);
        add_known(ACT_DISPLAY, '0, STAT_EMPTY, '0);
        add_item(ACT_UNUSED, 32'sd5);
        add_known(ACT_ENQUEUE, 32'sh7FFF_FFFF, STAT_OK, '0);
        add_known(ACT_ENQUEUE, 32'sh8000_0000, STAT_OK, '0);
        add_known(ACT_ENQUEUE, '0, STAT_OK, '0);
        add_known(ACT_ENQUEUE, '1, STAT_OK, '0);
        add_item(ACT_DISPLAY, '0);
        add_known(ACT_DEQUEUE, '0, STAT_OK, 32'sh7FFF_FFFF);
        add_known(ACT_DEQUEUE, '0, STAT_OK, 32'sh8000_0000);
        add_item(ACT_UNUSED, '1);
        add_item(ACT_DISPLAY, '0);
        // A zero capacity is taken as one slot, and the write empties the queue.
        add_capacity(5'd0);
        add_known(ACT_DISPLAY, '0, STAT_EMPTY, '0);
        add_known(ACT_ENQUEUE, 32'sh1234_5678, STAT_OK, '0);
        add_known(ACT_ENQUEUE, 32'sh0BAD_F00D, STAT_FULL, '0);
        add_item(ACT_DISPLAY, '0);
        add_known(ACT_DEQUEUE, '0, STAT_OK, 32'sh1234_5678);
        add_known(ACT_DEQUEUE, '0, STAT_EMPTY, '0);
        // Two slots: the tail wraps round behind the head.
        add_capacity(5'd2);
        add_known(ACT_ENQUEUE, 32'shAAAA_AAAA, STAT_OK, '0);
        add_known(ACT_ENQUEUE, 32'sh5555_5555, STAT_OK, '0);
        add_known(ACT_DEQUEUE, '0, STAT_OK, 32'shAAAA_AAAA);
        add_known(ACT_ENQUEUE, 32'sd1, STAT_OK, '0);
        add_item(ACT_DISPLAY, '0);
        add_known(ACT_ENQUEUE, 32'sd2, STAT_FULL, '0);
        // Oversized capacity is clamped to the full depth.
        add_capacity(5'd31);
        add_known(ACT_DEQUEUE, '0, STAT_EMPTY, '0);

        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;

        foreach (stim_table[i])
        begin
            if (stim_table[i].kind == ROW_CAPACITY)
                write_capacity(stim_table[i].cap);
            else
                send_item(stim_table[i].act, stim_table[i].val, stim_table[i].typed,
                          stim_table[i].t_status, stim_table[i].t_data);
        end

        // Random phases: fill towards full, then drain towards empty.
        random_items = 0;
        phase = 0;
        while (random_items < RANDOM_ITEMS)
        begin
            cap_value = (phase < 6) ? cap_plan[phase] : CAP_W'($urandom_range(0, 31));
            write_capacity(cap_value);
            eff_cap = ring_cap;
            no_idle = ($urandom_range(0, 3) == 0);
            phase_len = 2 * eff_cap + $urandom_range(4, 12);
            for (int i = 0; i < phase_len && random_items < RANDOM_ITEMS; i++)
            begin
                // Once, stop sending mid-phase until the core has caught up.
                if (phase == 2 && i == phase_len / 2)
                    drain_outputs();
                act = pick_action(i < phase_len / 2);
                send_item(act, pick_value(), 1'b0, STAT_OK, '0);
                if (act != ACT_UNUSED)
                    random_items++;
            end
            phase++;
        end
        no_idle = 1'b0;

        drain_outputs();
        $display("Ran %0d actions over %0d capacity writes; %0d words checked.",
                 items_sent, cap_writes, words_seen);
        $display("Saw %0d full and %0d empty reports; longest listing %0d entries.",
                 full_seen, empty_seen, longest_list);
        if (failures == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule
